// ===== design/fsts_pkg.sv =====
// ----------------------------------------------------------------------------
// fsts_pkg
// shared widths and constants of the fixed-step tick scheduler
// ----------------------------------------------------------------------------
package fsts_pkg;

  // time values, tick rate, frame counter and average
  localparam int TIME_W   = 48;
  localparam int RATE_W   = 20;
  localparam int FRAMES_W = 32;
  localparam int AVG_W    = 32;

  // products of a time value and a 20-bit factor
  localparam int PROD_W = TIME_W + RATE_W;
  // shared add/sub unit, one guard bit above the widest product
  localparam int ADD_W  = PROD_W + 1;

  // divider: divisor is the frame count or the tick rate
  localparam int DVS_W = FRAMES_W;
  localparam int REM_W = DVS_W + 1;

  // step counter of the multiply and divide loops
  localparam int CNT_W = $clog2(TIME_W);

  localparam logic [RATE_W-1:0] US_PER_S   = RATE_W'(1000000);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);

endpackage

// ===== design/fsts_addsub.sv =====
// ----------------------------------------------------------------------------
// fsts_addsub
// shared adder/subtractor with carry out, used by every sequencer step
// ----------------------------------------------------------------------------
module fsts_addsub (
  input  logic [fsts_pkg::ADD_W-1:0] a_i,
  input  logic [fsts_pkg::ADD_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [fsts_pkg::ADD_W-1:0] sum_o,
  output logic                       carry_o
);
  import fsts_pkg::*;

  logic [ADD_W-1:0] b_op;

  assign b_op = sub_i ? ~b_i : b_i;

  // on subtract, carry high means no borrow (a >= b)
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_op} + {{ADD_W{1'b0}}, sub_i};

endmodule

// ===== design/fixed_step_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_scheduler
// frame clock with a fixed-rate tick scheduler, one shared add/sub unit
// ----------------------------------------------------------------------------
// sequence: a first frame goes straight to the result; a new frame takes the
//   elapsed time and window span, plus a 48-step restoring divide when the
//   window closes; a tick query runs two 20-step shift-add multiplies and a
//   compare if a tick can be due, and a 48-step divide when one is issued
// throughput: one word at a time, set by the shared add/sub unit that every
//   sequencer step goes through; a new word is taken while a result waits
// reset: asynchronous active low; tick rate back to 60, all counters and times
//   zero, not started; no clearing pass
// ----------------------------------------------------------------------------
module fixed_step_tick_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [fsts_pkg::TIME_W-1:0]   frame_time_us_i,

  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          tick_due_o,
  output logic [fsts_pkg::TIME_W-1:0]   tick_count_o,
  output logic [fsts_pkg::TIME_W-1:0]   tick_time_us_o,
  output logic [fsts_pkg::TIME_W-1:0]   elapsed_us_o,
  output logic [fsts_pkg::AVG_W-1:0]    avg_frame_time_us_o,

  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fsts_pkg::*;

  // register index lives in paddr[2]
  localparam logic REG_TPS = 1'b0;

  // opcodes
  localparam logic OP_FRAME = 1'b0;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_W - 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_FR_ELAP = 9'b000000010,
    ST_FR_SPAN = 9'b000000100,
    ST_FR_CMP  = 9'b000001000,
    ST_MUL_A   = 9'b000010000,
    ST_MUL_B   = 9'b000100000,
    ST_TQ_CMP  = 9'b001000000,
    ST_DIVIDE  = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_e;

  state_e state_q;

  // architectural state
  logic [RATE_W-1:0]   tps_q;
  logic                started_q;
  logic [TIME_W-1:0]   start_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic [TIME_W-1:0]   ticks_q;
  logic [TIME_W-1:0]   last_tick_q;
  logic [TIME_W-1:0]   win_start_q;
  logic [FRAMES_W-1:0] win_frames_q;
  logic [AVG_W-1:0]    avg_q;

  // sequencer and datapath
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  logic                op_q;
  logic                due_q;
  logic [TIME_W-1:0]   t_q;
  logic [PROD_W-1:0]   acc_q;
  logic [PROD_W-1:0]   mcand_q;
  logic [RATE_W-1:0]   mplier_q;
  logic [PROD_W-1:0]   a_q;
  logic [TIME_W-1:0]   dvd_q;
  logic [REM_W-1:0]    rem_q;
  logic [DVS_W-1:0]    dvs_q;

  // shared unit hookup
  logic [ADD_W-1:0]    add_a;
  logic [ADD_W-1:0]    add_b;
  logic                add_sub;
  logic [ADD_W-1:0]    add_sum;
  logic                add_carry;

  logic                cfg_wr;
  logic                accept;
  logic                out_load;
  logic                tick_full;
  logic [TIME_W:0]     ticks_inc;
  logic [PROD_W-1:0]   acc_next;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    rem_next;
  logic [TIME_W-1:0]   dvd_next;
  logic [AVG_W-1:0]    avg_sat;

  // --------------------------------------------------------------------------
  // register port, always ready
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TPS);
  assign prdata = (paddr[2] == REG_TPS) ? {{(32-RATE_W){1'b0}}, tps_q} : 32'd0;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  // result register frees up in the same cycle it is taken
  assign out_load    = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);

  // --------------------------------------------------------------------------
  // small helpers around the shared unit
  // --------------------------------------------------------------------------
  assign tick_full = &ticks_q;
  assign ticks_inc = {1'b0, ticks_q} + (TIME_W+1)'(1);

  // shift-add step: add the shifted multiplicand when the low bit is set
  assign acc_next = mplier_q[0] ? add_sum[PROD_W-1:0] : acc_q;

  // restoring divide step: bring in the next dividend bit, keep the
  // difference when it did not borrow, quotient bits shift in from below
  assign rem_sh   = {rem_q[REM_W-2:0], dvd_q[TIME_W-1]};
  assign rem_next = add_carry ? add_sum[REM_W-1:0] : rem_sh;
  assign dvd_next = {dvd_q[TIME_W-2:0], add_carry};

  // average clamps to 32 bits
  assign avg_sat = (|dvd_next[TIME_W-1:AVG_W]) ? {AVG_W{1'b1}} : dvd_next[AVG_W-1:0];

  // operand select for the shared unit
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      ST_FR_ELAP: begin
        // timestamp minus start, wraps at the time width
        add_a   = {{(ADD_W-TIME_W){1'b0}}, t_q};
        add_b   = {{(ADD_W-TIME_W){1'b0}}, start_q};
        add_sub = 1'b1;
      end
      ST_FR_SPAN: begin
        add_a   = {{(ADD_W-TIME_W){1'b0}}, elapsed_q};
        add_b   = {{(ADD_W-TIME_W){1'b0}}, win_start_q};
        add_sub = 1'b1;
      end
      ST_FR_CMP: begin
        // span against one second
        add_a   = {{(ADD_W-TIME_W){1'b0}}, dvd_q};
        add_b   = {{(ADD_W-RATE_W){1'b0}}, US_PER_S};
        add_sub = 1'b1;
      end
      ST_MUL_A, ST_MUL_B: begin
        add_a   = {1'b0, acc_q};
        add_b   = {1'b0, mcand_q};
      end
      ST_TQ_CMP: begin
        // elapsed * rate minus (ticks + 1) * 1e6
        add_a   = {1'b0, acc_q};
        add_b   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      ST_DIVIDE: begin
        add_a   = {{(ADD_W-REM_W){1'b0}}, rem_sh};
        add_b   = {{(ADD_W-DVS_W){1'b0}}, dvs_q};
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  fsts_addsub u_addsub (
    .a_i     (add_a),
    .b_i     (add_b),
    .sub_i   (add_sub),
    .sum_o   (add_sum),
    .carry_o (add_carry)
  );

  // --------------------------------------------------------------------------
  // sequencer and architectural state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tps_q        <= RATE_RESET;
      started_q    <= 1'b0;
      start_q      <= '0;
      elapsed_q    <= '0;
      ticks_q      <= '0;
      last_tick_q  <= '0;
      win_start_q  <= '0;
      win_frames_q <= '0;
      avg_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tps_q <= pwdata[RATE_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (opcode_i == OP_FRAME) begin
              if (!started_q) begin
                // first frame latches the start time
                started_q   <= 1'b1;
                start_q     <= frame_time_us_i;
                elapsed_q   <= '0;
                last_tick_q <= '0;
                state_q     <= ST_DONE;
              end else begin
                state_q <= ST_FR_ELAP;
              end
            end else if (tick_full || (tps_q == '0)) begin
              // count full or rate zero: never due
              state_q <= ST_DONE;
            end else begin
              cnt_q   <= MUL_LAST;
              state_q <= ST_MUL_A;
            end
          end
        end
        ST_FR_ELAP: begin
          elapsed_q <= add_sum[TIME_W-1:0];
          if (~&win_frames_q) begin
            win_frames_q <= win_frames_q + FRAMES_W'(1);
          end
          state_q <= ST_FR_SPAN;
        end
        ST_FR_SPAN: begin
          state_q <= ST_FR_CMP;
        end
        ST_FR_CMP: begin
          if (add_carry) begin
            // window closes: divisor already captured, restart window
            win_start_q  <= elapsed_q;
            win_frames_q <= '0;
            cnt_q        <= DIV_LAST;
            state_q      <= ST_DIVIDE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MUL_A: begin
          if (cnt_q == '0) begin
            cnt_q   <= MUL_LAST;
            state_q <= ST_MUL_B;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_MUL_B: begin
          if (cnt_q == '0) begin
            state_q <= ST_TQ_CMP;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_TQ_CMP: begin
          if (add_carry) begin
            ticks_q <= ticks_inc[TIME_W-1:0];
            cnt_q   <= DIV_LAST;
            state_q <= ST_DIVIDE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DIVIDE: begin
          if (cnt_q == '0) begin
            if (op_q == OP_FRAME) begin
              avg_q <= avg_sat;
            end else begin
              last_tick_q <= dvd_next;
            end
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers, no reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_i;
      t_q      <= frame_time_us_i;
      due_q    <= 1'b0;
      acc_q    <= '0;
      mcand_q  <= {{(PROD_W-TIME_W-1){1'b0}}, ticks_inc};
      mplier_q <= US_PER_S;
    end

    unique case (state_q)
      ST_FR_SPAN: begin
        dvd_q <= add_sum[TIME_W-1:0];
      end
      ST_FR_CMP: begin
        rem_q <= '0;
        dvs_q <= win_frames_q;
      end
      ST_MUL_A: begin
        if (cnt_q == '0) begin
          // first product parked, second one starts from zero
          a_q      <= acc_next;
          acc_q    <= '0;
          mcand_q  <= {{(PROD_W-TIME_W){1'b0}}, elapsed_q};
          mplier_q <= tps_q;
        end else begin
          acc_q    <= acc_next;
          mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[RATE_W-1:1]};
        end
      end
      ST_MUL_B: begin
        acc_q    <= acc_next;
        mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[RATE_W-1:1]};
      end
      ST_TQ_CMP: begin
        // quotient fits the time width, so the high part is below the rate
        due_q <= add_carry;
        rem_q <= {{(REM_W-RATE_W){1'b0}}, a_q[PROD_W-1:TIME_W]};
        dvd_q <= a_q[TIME_W-1:0];
        dvs_q <= {{(DVS_W-RATE_W){1'b0}}, tps_q};
      end
      ST_DIVIDE: begin
        rem_q <= rem_next;
        dvd_q <= dvd_next;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      tick_due_o          <= due_q;
      tick_count_o        <= ticks_q;
      tick_time_us_o      <= last_tick_q;
      elapsed_us_o        <= elapsed_q;
      avg_frame_time_us_o <= avg_q;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // divider remainder stays below the divisor across every step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (rem_q < {1'b0, dvs_q}))
    else $error("divider remainder not below divisor");

  // an issued tick means the count is at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tick_due_o) |-> (tick_count_o != '0))
    else $error("tick due with zero tick count");

  // an issued tick never lies past the elapsed time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tick_due_o) |-> (tick_time_us_o <= elapsed_us_o))
    else $error("tick time beyond elapsed time");

  // tick count only moves on a due compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TQ_CMP) |=> $stable(ticks_q))
    else $error("tick count changed outside the tick compare");

endmodule

// ===== tb/sv/fsts_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// fsts_tb_pkg
// operation codes and register map shared by the scheduler checker and bench
// ----------------------------------------------------------------------------
package fsts_tb_pkg;

  typedef enum logic {
    OP_NEW_FRAME  = 1'b0,
    OP_TICK_QUERY = 1'b1
  } fsts_op_e;

  // register byte addresses
  localparam logic [2:0] REG_TICK_RATE = 3'd0;

endpackage

// ===== tb/sv/fixed_step_tick_scheduler_chk.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_scheduler_chk
// watches the word channels and the register port, keeps its own frame clock
// and tick counter, and compares every result word with its prediction
// ----------------------------------------------------------------------------
module fixed_step_tick_scheduler_chk
  import fsts_pkg::*;
  import fsts_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              opcode_i,
  input  logic [TIME_W-1:0] frame_time_us_i,

  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              tick_due_i,
  input  logic [TIME_W-1:0] tick_count_i,
  input  logic [TIME_W-1:0] tick_time_us_i,
  input  logic [TIME_W-1:0] elapsed_us_i,
  input  logic [AVG_W-1:0]  avg_frame_time_us_i,

  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  input  logic              pready_i,

  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic              tick_due;
    logic [TIME_W-1:0] tick_count;
    logic [TIME_W-1:0] tick_time;
    logic [TIME_W-1:0] elapsed;
    logic [AVG_W-1:0]  avg_frame;
  } clock_word_t;

  clock_word_t expected_words[$];
  clock_word_t want;
  clock_word_t got;

  // predicted block state
  logic [RATE_W-1:0]   rate;
  logic                started;
  logic [TIME_W-1:0]   start_stamp;
  logic [TIME_W-1:0]   run_time;
  logic [TIME_W-1:0]   ticks;
  logic [TIME_W-1:0]   tick_stamp;
  logic [TIME_W-1:0]   win_start;
  logic [FRAMES_W-1:0] win_frames;
  logic [AVG_W-1:0]    avg_time;

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      if (errors_o <= 10)
        $display("%t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    end
  endtask

  task automatic advance_clock(input logic op, input logic [TIME_W-1:0] stamp,
                               output clock_word_t w);
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] mean;
    logic [127:0]      owed;
    logic [127:0]      earned;
    logic [127:0]      quot;
    w.tick_due = 1'b0;
    if (op == OP_NEW_FRAME) begin
      if (!started) begin
        started     = 1'b1;
        start_stamp = stamp;
        run_time    = '0;
        tick_stamp  = '0;
      end else begin
        run_time = stamp - start_stamp;
        if (win_frames != '1)
          win_frames++;
        span = run_time - win_start;
        if (span >= TIME_W'(US_PER_S)) begin
          mean     = span / TIME_W'(win_frames);
          avg_time = (mean > TIME_W'({AVG_W{1'b1}})) ? '1 : mean[AVG_W-1:0];
          win_start  = run_time;
          win_frames = '0;
        end
      end
    end else if (ticks != '1 && rate != '0) begin
      // exact compare of the next tick instant against elapsed time
      owed   = (128'(ticks) + 128'd1) * 128'(US_PER_S);
      earned = 128'(run_time) * 128'(rate);
      if (owed <= earned) begin
        ticks++;
        quot       = (128'(ticks) * 128'(US_PER_S)) / 128'(rate);
        tick_stamp = quot[TIME_W-1:0];
        w.tick_due = 1'b1;
      end
    end
    w.tick_count = ticks;
    w.tick_time  = tick_stamp;
    w.elapsed    = run_time;
    w.avg_frame  = avg_time;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate        = RATE_RESET;
      started     = 1'b0;
      start_stamp = '0;
      run_time    = '0;
      ticks       = '0;
      tick_stamp  = '0;
      win_start   = '0;
      win_frames  = '0;
      avg_time    = '0;
      expected_words.delete();
      pending_o   = 0;
      errors_o    = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == REG_TICK_RATE) begin
        if (pwrite_i)
          rate = pwdata_i[RATE_W-1:0];
        else
          check_field("tick rate readback", 64'(rate), 64'(prdata_i[RATE_W-1:0]));
      end
      // retire before predicting, so a word never matches its own prediction
      if (out_valid_i && out_ready_i) begin
        got = '{tick_due_i, tick_count_i, tick_time_us_i, elapsed_us_i,
                avg_frame_time_us_i};
        if (expected_words.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%t result word with nothing pending", $realtime);
        end else begin
          want = expected_words.pop_front();
          pending_o--;
          check_field("tick_due", 64'(want.tick_due), 64'(got.tick_due));
          check_field("tick_count", 64'(want.tick_count), 64'(got.tick_count));
          check_field("tick_time_us", 64'(want.tick_time), 64'(got.tick_time));
          check_field("elapsed_us", 64'(want.elapsed), 64'(got.elapsed));
          check_field("avg_frame_time_us", 64'(want.avg_frame), 64'(got.avg_frame));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_clock(opcode_i, frame_time_us_i, want);
        expected_words.push_back(want);
        pending_o++;
      end
    end
  end

endmodule

// ===== tb/sv/fixed_step_tick_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_scheduler_tb
// drives frame and tick-query words into the scheduler across several tick
// rates, with bursty input, stalling output and a long output hold-off; the
// checker beside the block predicts every result word and counts mismatches
// ----------------------------------------------------------------------------
module fixed_step_tick_scheduler_tb;
  import fsts_pkg::*;
  import fsts_tb_pkg::*;

  // cycles with no accepted word before the run is called hung; well above the
  // slowest word plus the long output hold-off
  localparam int IDLE_LIMIT  = 5000;
  // length of the deliberate output hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 200;
  // start time latched by the first frame
  localparam logic [TIME_W-1:0] ORIGIN = 48'h0000_0100_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = 1'b0;
  logic [TIME_W-1:0] frame_time = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              tick_due;
  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] tick_time;
  logic [TIME_W-1:0] elapsed;
  logic [AVG_W-1:0]  avg_frame;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                errors;
  int                pending;

  // sender burst bookkeeping and the one-shot hold-off request to the receiver
  int                burst_left = 0;
  bit                hold_req = 1'b0;
  int                quiet = 0;

  always #5 clk_i = ~clk_i;

  fixed_step_tick_scheduler i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .frame_time_us_i     (frame_time),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .tick_due_o          (tick_due),
    .tick_count_o        (tick_count),
    .tick_time_us_o      (tick_time),
    .elapsed_us_o        (elapsed),
    .avg_frame_time_us_o (avg_frame),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  fixed_step_tick_scheduler_chk i_chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .opcode_i            (opcode),
    .frame_time_us_i     (frame_time),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .tick_due_i          (tick_due),
    .tick_count_i        (tick_count),
    .tick_time_us_i      (tick_time),
    .elapsed_us_i        (elapsed),
    .avg_frame_time_us_i (avg_frame),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .prdata_i            (prdata),
    .pready_i            (pready),
    .errors_o            (errors),
    .pending_o           (pending)
  );

  // one input word; valid stays up inside a burst, a random gap opens
  // between bursts, and some bursts follow each other with no gap at all
  task automatic send_word(input fsts_op_e op, input logic [TIME_W-1:0] stamp);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= op;
    frame_time <= stamp;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // stop offering words until every result word is back, then let the block
  // settle before its register is touched
  task automatic drain_results();
    @(negedge clk_i);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // setup cycle, then access cycle; the upper data bits are random noise
  task automatic access_rate_reg(input logic wr, input logic [RATE_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_TICK_RATE;
    pwdata  <= {12'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: changes stall pattern at random intervals; on request it
  // holds off once for a long stretch so the block backs up into its input
  always begin : receiver
    int mode;
    int mode_left;
    int beat;
    bit held;
    mode_left = 0;
    beat      = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      beat++;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ready <= ($urandom_range(0, 1) != 0);
        end
        default: begin
          out_ready <= (beat % 5 != 4);
        end
      endcase
    end
  end

  // hang detection: any accepted word or register access restarts the count
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] frame_clock;
    logic [RATE_W-1:0] rate;
    int                draw;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset tick rate of 60
    send_word(OP_TICK_QUERY, '1);                  // query before first frame
    send_word(OP_NEW_FRAME, ORIGIN);               // first frame latches start
    send_word(OP_TICK_QUERY, '0);                  // elapsed still zero
    send_word(OP_NEW_FRAME, ORIGIN + 16667);       // first tick just reachable
    send_word(OP_TICK_QUERY, ORIGIN);
    send_word(OP_TICK_QUERY, ORIGIN);              // second tick not yet due
    send_word(OP_NEW_FRAME, ORIGIN + 1000000);     // one second: window closes
    send_word(OP_NEW_FRAME, '0);                   // before start, elapsed wraps, avg saturates
    send_word(OP_TICK_QUERY, '0);
    send_word(OP_NEW_FRAME, ORIGIN + 5000);        // elapsed below window start
    send_word(OP_NEW_FRAME, '1);                   // all-ones timestamp
    send_word(OP_NEW_FRAME, ORIGIN + 2000000);
    send_word(OP_TICK_QUERY, '1);
    send_word(OP_TICK_QUERY, '0);
    frame_clock = ORIGIN + 2000000;

    // random phases, each at its own tick rate including zero and the maximum
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       rate = RATE_RESET;
        1:       rate = RATE_W'(1);
        2:       rate = US_PER_S;
        3:       rate = '1;
        4:       rate = '0;
        5:       rate = RATE_W'(1000);
        default: rate = RATE_W'($urandom_range(1, 1000000));
      endcase
      access_rate_reg(1'b1, rate);
      access_rate_reg(1'b0, '0);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender pause until everything is back
        if (phase == 1 && n == PHASE_WORDS / 2)
          drain_results();
        // long output hold-off while words keep coming
        if (phase == 2 && n == PHASE_WORDS / 4)
          hold_req = 1'b1;

        draw = $urandom_range(0, 99);
        if (draw < 50) begin
          // the timestamp is ignored on a query but still toggles every bit
          send_word(OP_TICK_QUERY, TIME_W'({$urandom, $urandom}));
        end else if (draw < 88) begin
          // well-formed frame stream, now and then a gap of over a second
          if ($urandom_range(0, 19) == 0)
            frame_clock += TIME_W'($urandom_range(1000000, 3000000));
          else
            frame_clock += TIME_W'($urandom_range(1, 40000));
          send_word(OP_NEW_FRAME, frame_clock);
        end else if (draw < 96) begin
          // stray timestamp anywhere in the range
          send_word(OP_NEW_FRAME, TIME_W'({$urandom, $urandom}));
        end else begin
          // timestamp just before the start time
          send_word(OP_NEW_FRAME, ORIGIN - TIME_W'($urandom_range(0, 1000)));
        end
      end
    end

    drain_results();
    // longest word latency with some margin, to catch stray result words
    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
